// ===== src/tdf_pkg.sv =====
// Shared constants and types of the table-driven event state machine engine.
`timescale 1ns / 1ps

package tdf_pkg;

	// Fixed field widths of the channels
	localparam int EV_W = 16;
	localparam int STATE_W = 4;
	localparam int ACT_W = 8;
	localparam int POS_W = 9;

	// Opcodes of an input beat
	localparam logic [1:0] OP_PROCESS   = 2'd0;
	localparam logic [1:0] OP_WR_TRANS  = 2'd1;
	localparam logic [1:0] OP_WR_ACTION = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_TAKEN       = 3'd0;
	localparam logic [2:0] ST_GUARD       = 3'd1;
	localparam logic [2:0] ST_POS_RANGE   = 3'd2;
	localparam logic [2:0] ST_STATE_RANGE = 3'd3;
	localparam logic [2:0] ST_ACK         = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_EVENTS_PER_STATE = 2'd0;
	localparam logic [1:0] REG_TRANS_SIZE       = 2'd1;
	localparam logic [1:0] REG_ACTION_SIZE      = 2'd2;

	typedef logic [STATE_W-1:0] state_id_t;
	typedef logic [ACT_W-1:0]   action_id_t;
	typedef logic [EV_W-1:0]    event_vec_t;
	typedef logic [POS_W-1:0]   pos_t;

	// Configuration register set
	typedef struct packed {
		logic [4:0] events_per_state;
		logic [8:0] trans_size;
		logic [4:0] action_size;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		events_per_state: 5'd16,
		trans_size:       9'd256,
		action_size:      5'd16
	};

endpackage

// ===== src/tdf_if.sv =====
// Channel interfaces: input items, results and configuration writes.
`timescale 1ns / 1ps

interface tdf_in_if;
	import tdf_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	event_vec_t event_mask;
	event_vec_t guard_pass;
	logic [7:0] entry_index;
	state_id_t  entry_target;
	logic       entry_guarded;
	action_id_t entry_move_action;
	action_id_t entry_enter_action;
	action_id_t entry_leave_action;

	modport source (output valid, opcode, event_mask, guard_pass, entry_index, entry_target,
		entry_guarded, entry_move_action, entry_enter_action, entry_leave_action,
		input ready);
	modport sink (input valid, opcode, event_mask, guard_pass, entry_index, entry_target,
		entry_guarded, entry_move_action, entry_enter_action, entry_leave_action,
		output ready);
endinterface

interface tdf_out_if;
	import tdf_pkg::*;
	logic       valid;
	logic       ready;
	state_id_t  event_index;
	state_id_t  from_state;
	state_id_t  to_state;
	action_id_t leave_action;
	action_id_t move_action;
	action_id_t enter_action;
	logic [2:0] status;
	logic       last;

	modport source (output valid, event_index, from_state, to_state, leave_action,
		move_action, enter_action, status, last, input ready);
	modport sink (input valid, event_index, from_state, to_state, leave_action,
		move_action, enter_action, status, last, output ready);
endinterface

interface tdf_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] addr;
	logic [8:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== src/table_driven_event_fsm_top.sv =====
// Top level of the table-driven event state machine engine.
// A write or an empty mask gives its one result, an acknowledgement. Per set event bit:
// an out-of-range position is reported from the scan step, a state-range or guard stop
// after the transition read, and a taken transition after the transition read, then
// the action read. Throughput: one item at a time; the next item is taken once
// the last result sits in the output register. Reset clears state to 0 and the
// configuration to 16/256/16; the memories keep their contents and need no clearing pass.
`timescale 1ns / 1ps

module table_driven_event_fsm_top #(
	parameter int NUM_STATES     = 16,
	parameter int EVENT_BITS     = 16,
	parameter int TABLE_DEPTH    = 256,
	parameter int ACTION_ID_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	tdf_cfg_if.sink   cfg,
	tdf_in_if.sink    item,
	tdf_out_if.source result
);
	import tdf_pkg::*;

	localparam int TD_AW = $clog2(TABLE_DEPTH);
	localparam int SA_AW = $clog2(NUM_STATES);
	localparam int AIDW  = (ACTION_ID_BITS < 8) ? ACTION_ID_BITS : 8;
	localparam int TE_W  = 5 + AIDW;
	localparam int AE_W  = 2 * AIDW;

	cfg_t cfg_q;

	logic             trans_wr_en, trans_rd_en;
	logic [TD_AW-1:0] trans_wr_addr, trans_rd_addr;
	logic [TE_W-1:0]  trans_wr_data, trans_rd_data;
	logic             act_wr_en, act_rd_en;
	logic [SA_AW-1:0] act_wr_addr, act_rd_addr_from, act_rd_addr_to;
	logic [AE_W-1:0]  act_wr_data, act_rd_from, act_rd_to;

	// Configuration registers; writes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_EVENTS_PER_STATE: cfg_q.events_per_state <= cfg.data[4:0];
				REG_TRANS_SIZE:       cfg_q.trans_size       <= cfg.data;
				REG_ACTION_SIZE:      cfg_q.action_size      <= cfg.data[4:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	tdf_seq #(
		.NUM_STATES     (NUM_STATES),
		.EVENT_BITS     (EVENT_BITS),
		.TABLE_DEPTH    (TABLE_DEPTH),
		.ACTION_ID_BITS (ACTION_ID_BITS)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.item             (item),
		.result           (result),
		.trans_wr_en      (trans_wr_en),
		.trans_wr_addr    (trans_wr_addr),
		.trans_wr_data    (trans_wr_data),
		.trans_rd_en      (trans_rd_en),
		.trans_rd_addr    (trans_rd_addr),
		.trans_rd_data    (trans_rd_data),
		.act_wr_en        (act_wr_en),
		.act_wr_addr      (act_wr_addr),
		.act_wr_data      (act_wr_data),
		.act_rd_en        (act_rd_en),
		.act_rd_addr_from (act_rd_addr_from),
		.act_rd_addr_to   (act_rd_addr_to),
		.act_rd_from      (act_rd_from),
		.act_rd_to        (act_rd_to)
	);

	tdf_trans_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (TE_W)
	) u_trans_mem (
		.clk     (clk),
		.wr_en   (trans_wr_en),
		.wr_addr (trans_wr_addr),
		.wr_data (trans_wr_data),
		.rd_en   (trans_rd_en),
		.rd_addr (trans_rd_addr),
		.rd_data (trans_rd_data)
	);

	tdf_action_mem #(
		.DEPTH (NUM_STATES),
		.WIDTH (AE_W)
	) u_action_mem (
		.clk       (clk),
		.wr_en     (act_wr_en),
		.wr_addr   (act_wr_addr),
		.wr_data   (act_wr_data),
		.rd_en     (act_rd_en),
		.rd_addr_a (act_rd_addr_from),
		.rd_addr_b (act_rd_addr_to),
		.rd_data_a (act_rd_from),
		.rd_data_b (act_rd_to)
	);

endmodule

// ===== src/tdf_trans_mem.sv =====
// Transition memory: one write port, one synchronous read port.
`timescale 1ns / 1ps

module tdf_trans_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 13
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/tdf_action_mem.sv =====
// Per-state action memory: one write port, two synchronous read ports.
`timescale 1ns / 1ps

module tdf_action_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Both read ports share one enable
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== src/tdf_seq.sv =====
// Sequencer: walks the event bits, reads both memories and fills the result register.
`timescale 1ns / 1ps

module tdf_seq #(
	parameter int NUM_STATES     = 16,
	parameter int EVENT_BITS     = 16,
	parameter int TABLE_DEPTH    = 256,
	parameter int ACTION_ID_BITS = 8,
	localparam int TD_AW = $clog2(TABLE_DEPTH),
	localparam int SA_AW = $clog2(NUM_STATES),
	localparam int AIDW  = (ACTION_ID_BITS < 8) ? ACTION_ID_BITS : 8,
	localparam int TE_W  = 5 + AIDW,
	localparam int AE_W  = 2 * AIDW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tdf_pkg::cfg_t     cfg,
	tdf_in_if.sink            item,
	tdf_out_if.source         result,
	// transition memory
	output logic              trans_wr_en,
	output logic [TD_AW-1:0]  trans_wr_addr,
	output logic [TE_W-1:0]   trans_wr_data,
	output logic              trans_rd_en,
	output logic [TD_AW-1:0]  trans_rd_addr,
	input  logic [TE_W-1:0]   trans_rd_data,
	// action memory
	output logic              act_wr_en,
	output logic [SA_AW-1:0]  act_wr_addr,
	output logic [AE_W-1:0]   act_wr_data,
	output logic              act_rd_en,
	output logic [SA_AW-1:0]  act_rd_addr_from,
	output logic [SA_AW-1:0]  act_rd_addr_to,
	input  logic [AE_W-1:0]   act_rd_from,
	input  logic [AE_W-1:0]   act_rd_to
);
	import tdf_pkg::*;

	localparam int NB = (EVENT_BITS < EV_W) ? EVENT_BITS : EV_W;
	localparam event_vec_t EV_LIM = EV_W'((33'd1 << NB) - 33'd1);
	localparam event_vec_t EV_ONE = EV_W'(1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TRANS, S_ACT} seq_state_t;

	seq_state_t state_q, nstate;
	event_vec_t mask_q, guard_q, mask_n;
	state_id_t  cur_q, bit_q, tgt_q;
	logic [AIDW-1:0] mv_q;

	// result register
	logic       ov_q;
	state_id_t  o_ev_q, o_from_q, o_to_q;
	action_id_t o_lv_q, o_mv_q, o_en_q;
	logic [2:0] o_st_q;
	logic       o_last_q;

	logic       accept, out_free, emit;
	state_id_t  lb, e_ev, e_to;
	action_id_t e_lv, e_mv, e_en;
	logic [2:0] e_st;
	logic       e_last;
	pos_t       pos;
	logic [31:0] pos_ext, wr_idx_ext, cur_ext, tgt_ext;
	logic       pos_bad, state_bad, guard_bad;
	event_vec_t rest_scan, rest_bit;
	state_id_t  te_tgt;
	logic       te_grd;
	logic [AIDW-1:0] te_mv;

	assign accept   = item.valid && item.ready;
	assign out_free = !ov_q || result.ready;
	assign item.ready = (state_q == S_IDLE);

	// Table writes happen on the accept beat; reads come only later, so no overlap
	assign wr_idx_ext    = 32'(item.entry_index);
	assign trans_wr_en   = accept && (item.opcode == OP_WR_TRANS)
		&& (wr_idx_ext < 32'(TABLE_DEPTH));
	assign trans_wr_addr = wr_idx_ext[TD_AW-1:0];
	assign trans_wr_data = {item.entry_move_action[AIDW-1:0], item.entry_guarded,
		item.entry_target};
	assign act_wr_en     = accept && (item.opcode == OP_WR_ACTION)
		&& (wr_idx_ext < 32'(NUM_STATES));
	assign act_wr_addr   = wr_idx_ext[SA_AW-1:0];
	assign act_wr_data   = {item.entry_leave_action[AIDW-1:0],
		item.entry_enter_action[AIDW-1:0]};

	// Lowest pending event bit
	always_comb begin
		lb = '0;
		for (int i = EV_W - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				lb = STATE_W'(i);
			end
		end
	end

	// Table position and bounds
	assign pos       = POS_W'(cur_q) * POS_W'(cfg.events_per_state) + POS_W'(lb);
	assign pos_ext   = 32'(pos);
	assign pos_bad   = (pos >= cfg.trans_size) || (pos_ext >= 32'(TABLE_DEPTH));
	assign rest_scan = mask_q & ~(EV_ONE << lb);
	assign rest_bit  = mask_q & ~(EV_ONE << bit_q);
	assign trans_rd_addr = pos_ext[TD_AW-1:0];

	// Transition entry fields and checks
	assign te_tgt    = trans_rd_data[3:0];
	assign te_grd    = trans_rd_data[4];
	assign te_mv     = trans_rd_data[TE_W-1:5];
	assign cur_ext   = 32'(cur_q);
	assign tgt_ext   = 32'(te_tgt);
	assign state_bad = ({1'b0, te_tgt} >= cfg.action_size) || ({1'b0, cur_q} >= cfg.action_size)
		|| (tgt_ext >= 32'(NUM_STATES)) || (cur_ext >= 32'(NUM_STATES));
	assign guard_bad = te_grd && !guard_q[bit_q];
	assign act_rd_addr_from = cur_ext[SA_AW-1:0];
	assign act_rd_addr_to   = tgt_ext[SA_AW-1:0];

	// Next state and result to emit
	always_comb begin
		emit        = 1'b0;
		e_ev        = '0;
		e_to        = cur_q;
		e_lv        = '0;
		e_mv        = '0;
		e_en        = '0;
		e_st        = ST_ACK;
		e_last      = 1'b1;
		nstate      = state_q;
		mask_n      = mask_q;
		trans_rd_en = 1'b0;
		act_rd_en   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					nstate = S_SCAN;
				end
			end
			S_SCAN: begin
				if (mask_q == '0) begin
					// write, unused opcode or empty mask: acknowledge
					if (out_free) begin
						emit   = 1'b1;
						nstate = S_IDLE;
					end
				end else if (pos_bad) begin
					e_ev   = lb;
					e_st   = ST_POS_RANGE;
					e_last = (rest_scan == '0);
					if (out_free) begin
						emit   = 1'b1;
						mask_n = rest_scan;
						nstate = (rest_scan == '0) ? S_IDLE : S_SCAN;
					end
				end else begin
					trans_rd_en = 1'b1;
					nstate      = S_TRANS;
				end
			end
			S_TRANS: begin
				e_ev   = bit_q;
				e_last = (rest_bit == '0);
				if (state_bad || guard_bad) begin
					e_st = state_bad ? ST_STATE_RANGE : ST_GUARD;
					if (out_free) begin
						emit   = 1'b1;
						mask_n = rest_bit;
						nstate = (rest_bit == '0) ? S_IDLE : S_SCAN;
					end
				end else begin
					act_rd_en = 1'b1;
					nstate    = S_ACT;
				end
			end
			S_ACT: begin
				e_ev   = bit_q;
				e_to   = tgt_q;
				e_mv   = ACT_W'(mv_q);
				e_st   = ST_TAKEN;
				e_last = (rest_bit == '0);
				// leave and enter actions only on a real state change
				if (tgt_q != cur_q) begin
					e_lv = ACT_W'(act_rd_from[AE_W-1:AIDW]);
					e_en = ACT_W'(act_rd_to[AIDW-1:0]);
				end
				if (out_free) begin
					emit   = 1'b1;
					mask_n = rest_bit;
					nstate = (rest_bit == '0) ? S_IDLE : S_SCAN;
				end
			end
			default: begin
				nstate = S_IDLE;
			end
		endcase
	end

	// State, working registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			mask_q   <= '0;
			guard_q  <= '0;
			bit_q    <= '0;
			tgt_q    <= '0;
			mv_q     <= '0;
			ov_q     <= 1'b0;
			o_ev_q   <= '0;
			o_from_q <= '0;
			o_to_q   <= '0;
			o_lv_q   <= '0;
			o_mv_q   <= '0;
			o_en_q   <= '0;
			o_st_q   <= ST_ACK;
			o_last_q <= 1'b0;
		end else begin
			state_q <= nstate;
			if (accept) begin
				mask_q  <= (item.opcode == OP_PROCESS) ? (item.event_mask & EV_LIM) : '0;
				guard_q <= item.guard_pass;
			end else begin
				mask_q <= mask_n;
			end
			if (trans_rd_en) begin
				bit_q <= lb;
			end
			if (act_rd_en) begin
				tgt_q <= te_tgt;
				mv_q  <= te_mv;
			end
			if (emit && (state_q == S_ACT)) begin
				cur_q <= tgt_q;
			end
			if (emit) begin
				ov_q     <= 1'b1;
				o_ev_q   <= e_ev;
				o_from_q <= cur_q;
				o_to_q   <= e_to;
				o_lv_q   <= e_lv;
				o_mv_q   <= e_mv;
				o_en_q   <= e_en;
				o_st_q   <= e_st;
				o_last_q <= e_last;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign result.valid        = ov_q;
	assign result.event_index  = o_ev_q;
	assign result.from_state   = o_from_q;
	assign result.to_state     = o_to_q;
	assign result.leave_action = o_lv_q;
	assign result.move_action  = o_mv_q;
	assign result.enter_action = o_en_q;
	assign result.status       = o_st_q;
	assign result.last         = o_last_q;

endmodule

// ===== src/tdf_checker.sv =====
// Port-level checker for the engine and its bind to the top level.
`timescale 1ns / 1ps

module tdf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] from_state,
	input logic [3:0] to_state,
	input logic [7:0] leave_action,
	input logic [7:0] move_action,
	input logic [7:0] enter_action,
	input logic [2:0] status,
	input logic       last
);
	import tdf_pkg::*;

	// A stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last)
			&& $stable(to_state) && $stable(move_action))
		else $error("result beat changed while stalled");

	// One item at a time: no new item right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// An acknowledgement is always the only result of its item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ACK) |-> last)
		else $error("acknowledgement without last");

	// Anything but a taken transition leaves the state and actions alone
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_TAKEN) |-> (to_state == from_state)
			&& (leave_action == '0) && (move_action == '0) && (enter_action == '0))
		else $error("non-taken result moved state or ran actions");

	// Leave and enter actions only on a state change
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TAKEN) && (to_state == from_state)
			|-> (leave_action == '0) && (enter_action == '0))
		else $error("leave or enter action without a state change");

endmodule

bind table_driven_event_fsm_top tdf_checker u_tdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.from_state   (result.from_state),
	.to_state     (result.to_state),
	.leave_action (result.leave_action),
	.move_action  (result.move_action),
	.enter_action (result.enter_action),
	.status       (result.status),
	.last         (result.last)
);

// ===== verif/tdf_action_tracker.sv =====
// Monitor of the engine's channels: predicts every result beat and compares it.
`timescale 1ns / 1ps

module tdf_action_tracker (
	input  logic               clk,
	input  logic               arst_n,
	tdf_cfg_if                 cfg,
	tdf_in_if                  item,
	tdf_out_if                 result,
	output int                 fail_count,
	output int                 pending,
	output tdf_pkg::state_id_t fsm_state
);
	import tdf_pkg::*;

	localparam int N_STATES = 16;
	localparam int N_POS    = 256;
	localparam int N_EVENTS = 16;
	localparam int N_REPORT = 10;

	typedef struct packed {
		state_id_t  ev;
		state_id_t  from_st;
		state_id_t  to_st;
		action_id_t leave;
		action_id_t move;
		action_id_t enter;
		logic [2:0] status;
		logic       last;
	} fsm_result_t;

	// Shadow copy of registers and tables
	cfg_t        regs;
	state_id_t   tr_target  [N_POS];
	logic        tr_guarded [N_POS];
	action_id_t  tr_move    [N_POS];
	action_id_t  st_enter   [N_STATES];
	action_id_t  st_leave   [N_STATES];
	fsm_result_t results_due[$];

	function automatic string fmt(fsm_result_t r);
		return $sformatf("ev=%0d from=%0d to=%0d leave=%02h move=%02h enter=%02h status=%0d last=%0d",
			r.ev, r.from_st, r.to_st, r.leave, r.move, r.enter, r.status, r.last);
	endfunction

	// Update the tables or walk the event mask for one accepted input beat
	task automatic predict_beat();
		fsm_result_t r;
		state_id_t   from;
		state_id_t   tgt;
		int          pos;
		int          b;
		bit          any;
		any = 1'b0;
		case (item.opcode)
			OP_WR_TRANS: begin
				tr_target[item.entry_index]  = item.entry_target;
				tr_guarded[item.entry_index] = item.entry_guarded;
				tr_move[item.entry_index]    = item.entry_move_action;
			end
			OP_WR_ACTION: begin
				// indexes beyond the state count are dropped silently
				if (item.entry_index < N_STATES) begin
					st_enter[item.entry_index[3:0]] = item.entry_enter_action;
					st_leave[item.entry_index[3:0]] = item.entry_leave_action;
				end
			end
			OP_PROCESS: begin
				for (b = 0; b < N_EVENTS; b++) begin
					if (item.event_mask[b]) begin
						any  = 1'b1;
						from = fsm_state;
						pos  = int'(from) * int'(regs.events_per_state) + b;
						r = '{ev: state_id_t'(b), from_st: from, to_st: from, leave: '0, move: '0,
							enter: '0, status: ST_TAKEN,
							last: ((32'(item.event_mask) >> (b + 1)) == 0)};
						if (pos >= int'(regs.trans_size) || pos >= N_POS) begin
							r.status = ST_POS_RANGE;
						end else begin
							tgt = tr_target[pos];
							if (tgt >= regs.action_size || from >= regs.action_size) begin
								r.status = ST_STATE_RANGE;
							end else if (tr_guarded[pos] && !item.guard_pass[b]) begin
								r.status = ST_GUARD;
							end else begin
								r.to_st = tgt;
								r.move  = tr_move[pos];
								// leave/enter ids only on a real state change
								if (tgt != from) begin
									r.leave = st_leave[from];
									r.enter = st_enter[tgt];
								end
								fsm_state = tgt;
							end
						end
						results_due.push_back(r);
					end
				end
			end
			default: ;
		endcase
		// writes, the unused opcode and an empty mask give a single ack
		if (!any) begin
			results_due.push_back('{ev: '0, from_st: fsm_state, to_st: fsm_state, leave: '0,
				move: '0, enter: '0, status: ST_ACK, last: 1'b1});
		end
	endtask

	// Compare one accepted result beat with the oldest expectation
	task automatic check_beat();
		fsm_result_t got;
		fsm_result_t want;
		got = '{ev: result.event_index, from_st: result.from_state, to_st: result.to_state,
			leave: result.leave_action, move: result.move_action, enter: result.enter_action,
			status: result.status, last: result.last};
		if (results_due.size() == 0) begin
			fail_count++;
			if (fail_count <= N_REPORT)
				$display("[%0t] result beat with nothing expected: %s", $realtime, fmt(got));
		end else begin
			want = results_due.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= N_REPORT) begin
					$display("[%0t] result mismatch", $realtime);
					$display("  expected %s", fmt(want));
					$display("  actual   %s", fmt(got));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs       = CFG_RESET;
			fsm_state  = '0;
			fail_count = 0;
			pending    = 0;
			results_due.delete();
		end else begin
			// results first: a new item never yields a beat in its own cycle
			if (result.valid && result.ready)
				check_beat();
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					REG_EVENTS_PER_STATE: regs.events_per_state = cfg.data[4:0];
					REG_TRANS_SIZE:       regs.trans_size       = cfg.data;
					REG_ACTION_SIZE:      regs.action_size      = cfg.data[4:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				predict_beat();
			pending = results_due.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: clock, reset, stimulus for the event engine and the final verdict.
`timescale 1ns / 1ps

module tb_top;
	import tdf_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int N_PHASES = 7;

	// Register settings per phase: extremes, masked out-of-range values and mid points
	localparam int PH_EPC   [N_PHASES] = '{16, 1, 1, 3, 31, 0, 16};
	localparam int PH_TSIZE [N_PHASES] = '{256, 0, 256, 40, 511, 100, 255};
	localparam int PH_ASIZE [N_PHASES] = '{16, 0, 16, 6, 31, 10, 15};
	localparam int PH_ITEMS [N_PHASES] = '{40, 15, 35, 35, 35, 35, 35};

	logic      clk;
	logic      arst_n;
	int        fail_count;
	int        pending;
	state_id_t fsm_state;
	bit        no_gap;
	bit        no_stall;
	int        quiet_cycles;

	tdf_cfg_if cfg_bus ();
	tdf_in_if  item_bus ();
	tdf_out_if result_bus ();

	table_driven_event_fsm_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (item_bus),
		.result (result_bus)
	);

	tdf_action_tracker i_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_bus),
		.item       (item_bus),
		.result     (result_bus),
		.fail_count (fail_count),
		.pending    (pending),
		.fsm_state  (fsm_state)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready)
				|| (result_bus.valid && result_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stall before each beat
	initial begin
		int stall;
		result_bus.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_stall ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			@(posedge clk);
			while (!result_bus.valid) @(posedge clk);
		end
	end

	task automatic cfg_beat(input logic [1:0] addr, input int value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.addr  <= addr;
		cfg_bus.data  <= 9'(value);
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	task automatic set_config(input int epc, input int tsize, input int asize);
		cfg_beat(REG_EVENTS_PER_STATE, epc);
		cfg_beat(REG_TRANS_SIZE, tsize);
		cfg_beat(REG_ACTION_SIZE, asize);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_beat(input logic [1:0] op, input event_vec_t mask,
			input event_vec_t guards, input logic [7:0] idx, input state_id_t tgt,
			input logic grd, input action_id_t mv, input action_id_t en, input action_id_t lv);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid              <= 1'b1;
		item_bus.opcode             <= op;
		item_bus.event_mask         <= mask;
		item_bus.guard_pass         <= guards;
		item_bus.entry_index        <= idx;
		item_bus.entry_target       <= tgt;
		item_bus.entry_guarded      <= grd;
		item_bus.entry_move_action  <= mv;
		item_bus.entry_enter_action <= en;
		item_bus.entry_leave_action <= lv;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
	endtask

	// Fields unused by an opcode get random values: the engine must ignore them
	task automatic write_trans(input logic [7:0] pos, input state_id_t tgt, input logic grd,
			input action_id_t mv);
		send_beat(OP_WR_TRANS, 16'($urandom), 16'($urandom), pos, tgt, grd, mv,
			8'($urandom), 8'($urandom));
	endtask

	task automatic write_actions(input logic [7:0] st, input action_id_t en,
			input action_id_t lv);
		send_beat(OP_WR_ACTION, 16'($urandom), 16'($urandom), st, 4'($urandom),
			1'($urandom), 8'($urandom), en, lv);
	endtask

	task automatic process(input event_vec_t mask, input event_vec_t guards);
		send_beat(OP_PROCESS, mask, guards, 8'($urandom), 4'($urandom), 1'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Wait until every expected result has come back, then let the pipe settle
	task automatic settle();
		item_bus.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly process beats; targets biased into the valid state range
	task automatic send_random_item(input int asize);
		int         sel;
		event_vec_t mask;
		event_vec_t guards;
		state_id_t  tgt;
		logic [7:0] idx;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			mask = '0;
		else if (sel < 3)
			mask = event_vec_t'(1) << $urandom_range(0, 15);
		else if (sel < 6)
			mask = 16'($urandom) & 16'($urandom);
		else if (sel < 9)
			mask = 16'($urandom);
		else
			mask = '1;
		sel = $urandom_range(0, 19);
		if (sel < 3)
			guards = '1;
		else if (sel < 6)
			guards = '0;
		else
			guards = 16'($urandom);
		if (asize == 0 || $urandom_range(0, 6) == 0)
			tgt = 4'($urandom);
		else
			tgt = 4'($urandom_range(0, (asize > 16 ? 16 : asize) - 1));
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			process(mask, guards);
		end else if (sel < 16) begin
			write_trans(8'($urandom), tgt, 1'($urandom), 8'($urandom));
		end else if (sel < 19) begin
			idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(16, 255))
				: 8'($urandom_range(0, 15));
			write_actions(idx, 8'($urandom), 8'($urandom));
		end else begin
			send_beat(OP_UNUSED, mask, guards, 8'($urandom), tgt, 1'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int ph;
		int n;
		arst_n                      = 1'b0;
		no_gap                      = 1'b0;
		no_stall                    = 1'b0;
		quiet_cycles                = 0;
		cfg_bus.valid               = 1'b0;
		cfg_bus.addr                = '0;
		cfg_bus.data                = '0;
		item_bus.valid              = 1'b0;
		item_bus.opcode             = OP_PROCESS;
		item_bus.event_mask         = '0;
		item_bus.guard_pass         = '0;
		item_bus.entry_index        = '0;
		item_bus.entry_target       = '0;
		item_bus.entry_guarded      = 1'b0;
		item_bus.entry_move_action  = '0;
		item_bus.entry_enter_action = '0;
		item_bus.entry_leave_action = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(PH_EPC[0], PH_TSIZE[0], PH_ASIZE[0]);

		// Load every table entry so no later lookup hits an unwritten slot
		for (n = 0; n < 256; n++)
			write_trans(8'(n), 4'($urandom), 1'($urandom), 8'($urandom));
		for (n = 0; n < 16; n++)
			write_actions(8'(n), 8'($urandom), 8'($urandom));

		// Directed: machine sits in state 0 here
		process(16'h0000, 16'hFFFF);
		write_trans(8'd0, 4'd0, 1'b0, 8'h55);
		process(16'h0001, 16'h0000);
		write_trans(8'd1, 4'd5, 1'b1, 8'hFF);
		process(16'h0002, 16'h0000);
		write_actions(8'd0, 8'hAA, 8'h11);
		write_actions(8'd5, 8'hFF, 8'h00);
		process(16'h0002, 16'hFFFF);
		write_actions(8'd200, 8'h12, 8'h34);
		write_actions(8'hFF, 8'hFF, 8'hFF);
		send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF, 1'b1, 8'hFF, 8'hFF, 8'hFF);
		write_trans(8'hFF, 4'hF, 1'b1, 8'h00);
		process(16'hFFFF, 16'hFFFF);
		process(16'hFFFF, 16'h0000);
		process(16'h8000, 16'h7FFF);
		write_actions(8'd15, 8'h00, 8'hFF);
		process(16'hAAAA, 16'h5555);

		for (ph = 0; ph < N_PHASES; ph++) begin
			settle();
			// Back to defaults and home the machine to state 0 before a new setting
			set_config(PH_EPC[0], PH_TSIZE[0], PH_ASIZE[0]);
			if (fsm_state != '0) begin
				write_trans(8'(fsm_state * 16), 4'd0, 1'b0, 8'($urandom));
				process(16'h0001, 16'($urandom));
				settle();
			end
			set_config(PH_EPC[ph], PH_TSIZE[ph], PH_ASIZE[ph]);
			for (n = 0; n < PH_ITEMS[ph]; n++) begin
				// stretches with and without idle cycles on both sides
				if (n % 12 == 0) begin
					no_gap   = ($urandom_range(0, 2) == 0);
					no_stall = ($urandom_range(0, 2) == 0);
				end
				send_random_item(PH_ASIZE[ph]);
			end
		end
		settle();

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
